### src/krke_pkg.sv
`timescale 1ns / 1ps

package krke_pkg;

    localparam int NUM_G    = 18;
    localparam int NUM_M    = 4;
    localparam int NUM_L    = 5;
    localparam int NUM_KEYS = NUM_G + NUM_M + NUM_L;
    localparam int IDX_W    = $clog2(NUM_KEYS);
    localparam int G_LO_CNT = 12;

    localparam logic [7:0] KIND_G  = 8'h01;
    localparam logic [7:0] KIND_ML = 8'h02;

    localparam logic [7:0] G_SC_LO = 8'h3a;
    localparam logic [7:0] G_SC_HI = 8'h1e;

    localparam logic [7:0] G_CODE_BASE = 8'd167;
    localparam logic [7:0] M_CODE_BASE = 8'd187;
    localparam logic [7:0] L_CODE_BASE = 8'd191;

    localparam logic [7:0] M1_MASK = 8'h01;
    localparam logic [7:0] M2_MASK = 8'h02;
    localparam logic [7:0] M3_MASK = 8'h04;
    localparam logic [7:0] M4_MASK = 8'h40;
    localparam logic [7:0] L_MASK  = 8'h80;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    typedef struct packed {
        logic capture;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic pend_any;
        logic out_free;
    } t_status;

endpackage

### src/krke_ctrl.sv
`timescale 1ns / 1ps

module krke_ctrl
    import krke_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (!i_status.pend_any) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/krke_datapath.sv
`timescale 1ns / 1ps

module krke_datapath
    import krke_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [7:0]  i_kind,
    input  logic [63:0] i_bytes,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic                r_single;
    logic [NUM_KEYS-1:0] r_held;
    logic [NUM_KEYS-1:0] r_now;
    logic [NUM_KEYS-1:0] r_pend;
    logic                r_phase;
    logic                r_out_valid;
    logic [7:0]          r_out_code;
    logic                r_out_pressed;
    logic                r_out_last;

    logic [7:0]          w_b [1:8];
    logic [NUM_KEYS-1:0] w_now;
    logic [NUM_KEYS-1:0] w_grp;
    logic [NUM_KEYS-1:0] w_low;
    logic [NUM_KEYS-1:0] w_rem;
    logic [IDX_W-1:0]    w_idx;
    logic [7:0]          w_sc;
    logic [7:0]          w_code;
    logic                w_pressed;
    logic                w_done;
    logic                w_last;

    always_comb begin
        for (int j = 1; j <= 8; j++) begin
            w_b[j] = i_bytes[(j-1)*8 +: 8];
        end
    end

    // decode the report into a held vector (G, then M, then L) and a group mask
    always_comb begin
        w_now = '0;
        w_grp = '0;
        w_sc  = '0;
        if (i_kind == KIND_G) begin
            w_grp[NUM_G-1:0] = '1;
            for (int i = 0; i < NUM_G; i++) begin
                if (i < G_LO_CNT) begin
                    w_sc = G_SC_LO + 8'(i);
                end else begin
                    w_sc = G_SC_HI + 8'(i - G_LO_CNT);
                end
                for (int j = 1; j <= 5; j++) begin
                    if (w_b[j] == w_sc) begin
                        w_now[i] = 1'b1;
                    end
                end
            end
        end else if (i_kind == KIND_ML) begin
            w_grp[NUM_KEYS-1:NUM_G] = '1;
            w_now[NUM_G+0] = |(w_b[6] & M1_MASK);
            w_now[NUM_G+1] = |(w_b[7] & M2_MASK);
            w_now[NUM_G+2] = |(w_b[8] & M3_MASK);
            w_now[NUM_G+3] = |(w_b[7] & M4_MASK);
            w_now[NUM_G+NUM_M+0] = |(w_b[8] & L_MASK);
            w_now[NUM_G+NUM_M+1] = |(w_b[2] & L_MASK);
            w_now[NUM_G+NUM_M+2] = |(w_b[3] & L_MASK);
            w_now[NUM_G+NUM_M+3] = |(w_b[4] & L_MASK);
            w_now[NUM_G+NUM_M+4] = |(w_b[5] & L_MASK);
        end
    end

    // lowest pending key
    assign w_low = r_pend & (~r_pend + {{(NUM_KEYS-1){1'b0}}, 1'b1});
    assign w_rem = r_pend & ~w_low;

    always_comb begin
        w_idx = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (w_low[k]) begin
                w_idx = w_idx | IDX_W'(k);
            end
        end
    end

    always_comb begin
        if (w_idx < IDX_W'(NUM_G)) begin
            w_code = G_CODE_BASE + 8'(w_idx);
        end else if (w_idx < IDX_W'(NUM_G + NUM_M)) begin
            w_code = M_CODE_BASE + 8'(w_idx) - 8'(NUM_G);
        end else begin
            w_code = L_CODE_BASE + 8'(w_idx) - 8'(NUM_G + NUM_M);
        end
    end

    // single mode: pending keys are presses only, each gives down then up
    assign w_pressed = r_single ? !r_phase : |(r_now & w_low);
    assign w_done    = !(r_single && !r_phase);
    assign w_last    = w_done && (w_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single    <= 1'b0;
            r_held      <= '0;
            r_pend      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_single <= i_cfg_wdata;
            end
            if (i_cmd.capture) begin
                r_held  <= (r_held & ~w_grp) | (w_now & w_grp);
                r_pend  <= (r_held ^ w_now) & w_grp & (w_now | {NUM_KEYS{!r_single}});
                r_phase <= 1'b0;
            end else if (i_cmd.step) begin
                if (w_done) begin
                    r_pend  <= w_rem;
                    r_phase <= 1'b0;
                end else begin
                    r_phase <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= w_now;
        end
        if (i_cmd.step) begin
            r_out_code    <= w_code;
            r_out_pressed <= w_pressed;
            r_out_last    <= w_last;
        end
    end

    assign o_status.pend_any = |r_pend;
    assign o_status.out_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pressed, r_out_code};
    assign m_axis_tlast  = r_out_last;

    a_phase_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_pend != '0))
        else $error("second half of a keypress with nothing pending");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && w_last) |=> (r_pend == '0))
        else $error("events remain after last");

    a_other_kind_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && i_kind != KIND_G && i_kind != KIND_ML) |=> (r_pend == '0))
        else $error("ignored report produced events");

    a_step_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (o_status.out_free && o_status.pend_any))
        else $error("step without pending key or free output");

endmodule

### src/key_report_to_key_events.sv
`timescale 1ns / 1ps
// The first event is offered after the report is captured into the pending
// vector and the scan result is registered at the output. A report holds the
// input until all E events (0..36) are out, one per cycle from a priority scan
// over the 27 pending keys. Output is registered; back-pressure stalls the scan.
// Reset (synchronous, active low) clears held keys, mode and output valid.

module key_report_to_key_events
    import krke_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // single_keypress
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // report_byte_1 .. report_byte_8
    input  logic [7:0]  s_axis_tuser,    // report_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // key_code[7:0], pressed[8], zero pad
    output logic        m_axis_tlast     // last
);

    t_cmd    w_cmd;
    t_status w_status;

    krke_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    krke_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (s_axis_tuser),
        .i_bytes       (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### test/tb_key_report_to_key_events.sv
`timescale 1ns / 1ps

module tb_key_report_to_key_events;
    import krke_pkg::*;

    typedef struct packed {
        logic [7:0]  kind;
        logic [63:0] body;   // byte 1 in the lowest bits
    } t_report;

    typedef struct packed {
        logic [7:0] code;
        logic       down;
        logic       last;
    } t_key_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // report_byte_1 .. report_byte_8
    logic [7:0]  s_axis_tuser;    // report_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // key_code[7:0], pressed[8], zero pad
    logic        m_axis_tlast;    // last

    t_report    pending_reports[$];
    t_key_event key_events_due[$];
    t_report    next_report;
    t_key_event due_evt;

    logic [NUM_G-1:0] g_held;
    logic [NUM_M-1:0] m_held;
    logic [NUM_L-1:0] l_held;
    logic             single_mode;

    bit report_taken;
    int snd_idle_pct;
    int rcv_stall_pct;
    int report_cnt;
    int ignored_cnt;
    int event_cnt;
    int err_cnt;

    key_report_to_key_events DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] g_scancode(input int i);
        return (i < G_LO_CNT) ? G_SC_LO + 8'(i) : G_SC_HI + 8'(i - G_LO_CNT);
    endfunction

    // Emit events for every key of one group whose held state changes; in single mode only presses, as down then up.
    task automatic diff_key_group(input logic [31:0] held_in, input logic [31:0] now,
                                  input int cnt, input logic [7:0] base,
                                  output logic [31:0] held_out, inout int n);
        t_key_event ev;
        held_out = held_in;
        for (int i = 0; i < cnt; i++) begin
            ev.code = base + 8'(i);
            ev.last = 1'b0;
            if (held_in[i] && !now[i]) begin
                if (!single_mode) begin
                    ev.down = 1'b0;
                    key_events_due.push_back(ev);
                    n++;
                end
                held_out[i] = 1'b0;
            end else if (!held_in[i] && now[i]) begin
                ev.down = 1'b1;
                key_events_due.push_back(ev);
                n++;
                if (single_mode) begin
                    ev.down = 1'b0;
                    key_events_due.push_back(ev);
                    n++;
                end
                held_out[i] = 1'b1;
            end
        end
    endtask

    task automatic predict_key_events(input t_report r);
        logic [7:0]  b [1:8];
        logic [31:0] now;
        logic [31:0] upd;
        t_key_event  tail;
        int          n;
        n = 0;
        now = '0;
        for (int j = 1; j <= 8; j++)
            b[j] = r.body[8*(j-1) +: 8];
        if (r.kind == KIND_G) begin
            for (int i = 0; i < NUM_G; i++)
                for (int j = 1; j <= 5; j++)
                    if (b[j] == g_scancode(i))
                        now[i] = 1'b1;
            diff_key_group(32'(g_held), now, NUM_G, G_CODE_BASE, upd, n);
            g_held = upd[NUM_G-1:0];
        end else if (r.kind == KIND_ML) begin
            now[0] = |(b[6] & M1_MASK);
            now[1] = |(b[7] & M2_MASK);
            now[2] = |(b[8] & M3_MASK);
            now[3] = |(b[7] & M4_MASK);
            diff_key_group(32'(m_held), now, NUM_M, M_CODE_BASE, upd, n);
            m_held = upd[NUM_M-1:0];
            now = '0;
            now[0] = |(b[8] & L_MASK);
            for (int j = 2; j <= 5; j++)
                now[j-1] = |(b[j] & L_MASK);
            diff_key_group(32'(l_held), now, NUM_L, L_CODE_BASE, upd, n);
            l_held = upd[NUM_L-1:0];
        end else begin
            ignored_cnt++;
        end
        if (n > 0) begin
            tail = key_events_due.pop_back();
            tail.last = 1'b1;
            key_events_due.push_back(tail);
        end
    endtask

    // Mostly valid scancodes in G reports; kind 2 bytes fully random.
    function automatic t_report rand_report();
        t_report r;
        int      pick;
        int      sel;
        pick = $urandom_range(99);
        r.body = {$urandom, $urandom};
        if (pick < 45) begin
            r.kind = KIND_G;
            for (int j = 0; j < 5; j++) begin
                sel = $urandom_range(9);
                if (sel < 7)
                    r.body[8*j +: 8] = g_scancode($urandom_range(NUM_G - 1));
                else if (sel < 8)
                    r.body[8*j +: 8] = 8'h00;
            end
        end else if (pick < 90) begin
            r.kind = KIND_ML;
        end else begin
            r.kind = 8'($urandom_range(255));
        end
        return r;
    endfunction

    task automatic add_report(input logic [7:0] kind, input logic [63:0] body);
        t_report r;
        r.kind = kind;
        r.body = body;
        pending_reports.push_back(r);
    endtask

    task automatic add_random(input int count);
        repeat (count) pending_reports.push_back(rand_report());
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while ((pending_reports.size() != 0 || s_axis_tvalid
                    || key_events_due.size() != 0) && guard < 20000);
        if (key_events_due.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d key events never arrived", $time, key_events_due.size());
            key_events_due.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    // driver: report beats and receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
            if (!s_axis_tvalid || report_taken) begin
                report_taken = 1'b0;
                if (pending_reports.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    next_report = pending_reports.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_report.body;
                    s_axis_tuser  <= next_report.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            g_held      = '0;
            m_held      = '0;
            l_held      = '0;
            single_mode = 1'b0;
        end else begin
            if (i_cfg_we)
                single_mode = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (key_events_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected event: code %0d pressed %0b last %0b",
                             $time, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
                end else begin
                    due_evt = key_events_due.pop_front();
                    event_cnt++;
                    if (due_evt.code !== m_axis_tdata[7:0] || due_evt.down !== m_axis_tdata[8]
                        || due_evt.last !== m_axis_tlast) begin
                        err_cnt++;
                        $display({"%0t: event mismatch: expected code %0d pressed %0b",
                                  " last %0b, got code %0d pressed %0b last %0b"},
                                 $time, due_evt.code, due_evt.down, due_evt.last,
                                 m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_key_events({s_axis_tuser, s_axis_tdata});
                report_taken = 1'b1;
                report_cnt++;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        report_taken  = 1'b0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        report_cnt    = 0;
        ignored_cnt   = 0;
        event_cnt     = 0;
        err_cnt       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // normal mode, no idling
        write_mode(1'b0);
        add_report(KIND_G, {24'h0, 8'h3e, 8'h3d, 8'h3c, 8'h3b, 8'h3a});
        add_report(KIND_G, {24'hffffff, 8'h3a, 8'h23, 8'h1e, 8'h45, 8'h3a});
        add_report(KIND_G, 64'h0);
        add_report(KIND_G, '1);
        add_report(KIND_ML, '1);
        add_report(KIND_ML, '1);
        add_report(KIND_ML, {8'h7b, 8'hbd, 8'hfe, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'hff});
        add_report(8'h00, '1);
        add_report(8'h03, '1);
        add_report(8'hff, '1);
        add_report(8'h81, {8'h84, 8'h42, 8'h01, 8'h80, 8'h3a, 8'h3b, 8'h80, 8'h23});
        add_report(KIND_ML, {8'h04, 8'h40, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
        add_report(KIND_G, {56'h0, 8'h23});
        add_random(80);
        wait_idle();

        // single keypress, sender idling; full drain halfway through
        write_mode(1'b1);
        snd_idle_pct = 55;
        add_report(KIND_G, {24'h0, 8'h1e, 8'h45, 8'h44, 8'h41, 8'h40});
        add_report(KIND_G, 64'h0);
        add_report(KIND_ML, '1);
        add_report(KIND_ML, 64'h0);
        add_random(40);
        wait_idle();
        add_random(40);
        add_report(KIND_G, {40'h0, 8'h00, 8'h23, 8'h3a});
        add_report(KIND_ML, {8'h00, 8'h40, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
        wait_idle();

        // back to normal: keys pressed in single mode now release with up events
        write_mode(1'b0);
        snd_idle_pct  = 0;
        rcv_stall_pct = 55;
        add_report(KIND_G, 64'h0);
        add_report(KIND_ML, 64'h0);
        add_random(80);
        wait_idle();

        write_mode(1'b1);
        snd_idle_pct  = 24;
        rcv_stall_pct = 24;
        add_random(80);
        wait_idle();

        $display("Sent %0d reports (%0d of other kinds), checked %0d key events",
                 report_cnt, ignored_cnt, event_cnt);
        $display("Both key modes, G and M/L reports, sender and receiver idling covered");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
